// ----- design/tcf_pkg.sv -----
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and constants for the tag column filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    // Character codes
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int TAG_LEN_W   = 4;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_BYTES  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_LENGTH = 1'd1;

    // Reset values of the config registers
    localparam logic [CFG_DATA_W-1:0] TAG_BYTES_RST  = 64'd68;
    localparam logic [TAG_LEN_W-1:0]  TAG_LENGTH_RST = 4'd1;

    // Line phase
    typedef enum logic [1:0] {
        PH_COL1 = 2'd0,
        PH_PASS = 2'd1,
        PH_SKIP = 2'd2
    } phase_t;

    // One step result toward the output register
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
    } result_t;

endpackage

// ----- design/tsv_tag_column_filter_core.sv -----
// ----------------------------------------------------------------------------
// tsv_tag_column_filter_core
// Passes the rest of each tab-separated line whose first column equals a
// configured tag, closing a passed line with a newline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid/in_ready   | in_byte, end_of_stream
//  out     | output    | out_valid/out_ready | out_byte
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One input word per cycle while in_ready is high; the result of a word, if
//  any, shows on out in the cycle after it is taken, held in the output register.
//  in_ready drops only while the output register is full and not drained.
//  cfg_ready is always high.
//  Reset puts the block at the start of a line with tag 'D', length 1.
// ----------------------------------------------------------------------------
module tsv_tag_column_filter_core #(
    parameter int MAX_TAG_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tcf_pkg::BYTE_W-1:0]          in_byte,
    input  logic                                end_of_stream,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tcf_pkg::BYTE_W-1:0]          out_byte,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [MAX_TAG_BYTES*8-1:0]        tag;
    logic [tcf_pkg::TAG_LEN_W-1:0]     tag_len;
    logic                              step;
    logic                              free;
    tcf_pkg::result_t                  result;

    assign in_ready = free;
    assign step     = in_valid & in_ready;

    // Configuration
    tcf_cfg_regs #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tag       (tag),
        .tag_len   (tag_len)
    );

    // Line state and compare
    tcf_line_fsm #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .tag           (tag),
        .tag_len       (tag_len),
        .result        (result)
    );

    // Result word register
    tcf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .result    (result),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte)
    );

endmodule

// ----- design/tcf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tcf_cfg_regs
// Configuration registers: tag characters and clamped tag length.
// ----------------------------------------------------------------------------
module tcf_cfg_regs #(
    parameter int MAX_TAG_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [MAX_TAG_BYTES*8-1:0]          tag,
    output logic [tcf_pkg::TAG_LEN_W-1:0]       tag_len
);

    localparam int TAG_W = MAX_TAG_BYTES * 8;
    localparam logic [tcf_pkg::TAG_LEN_W-1:0] MAX_LEN =
        tcf_pkg::TAG_LEN_W'(MAX_TAG_BYTES);

    logic [TAG_W-1:0]                  tag_reg, tag_next;
    logic [tcf_pkg::TAG_LEN_W-1:0]     len_reg, len_next;
    logic [tcf_pkg::TAG_LEN_W-1:0]     len_wr;
    logic                              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    // Length is stored already clamped to the tag storage
    assign len_wr = (cfg_data[tcf_pkg::TAG_LEN_W-1:0] > MAX_LEN) ?
                    MAX_LEN : cfg_data[tcf_pkg::TAG_LEN_W-1:0];

    // Write decode
    always_comb
    begin
        tag_next = tag_reg;
        len_next = len_reg;
        if (wr)
        begin
            unique case (cfg_index)
                tcf_pkg::REG_TAG_BYTES:  tag_next = cfg_data[TAG_W-1:0];
                tcf_pkg::REG_TAG_LENGTH: len_next = len_wr;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= tcf_pkg::TAG_BYTES_RST[TAG_W-1:0];
            len_reg <= (tcf_pkg::TAG_LENGTH_RST > MAX_LEN) ?
                       MAX_LEN : tcf_pkg::TAG_LENGTH_RST;
        end
        else
        begin
            tag_reg <= tag_next;
            len_reg <= len_next;
        end
    end

    assign tag     = tag_reg;
    assign tag_len = len_reg;

endmodule

// ----- design/tcf_line_fsm.sv -----
// ----------------------------------------------------------------------------
// tcf_line_fsm
// Per-line state: column one tag compare, pass and skip phases.
// ----------------------------------------------------------------------------
module tcf_line_fsm #(
    parameter int MAX_TAG_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [tcf_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            end_of_stream,
    input  logic [MAX_TAG_BYTES*8-1:0]      tag,
    input  logic [tcf_pkg::TAG_LEN_W-1:0]   tag_len,
    output tcf_pkg::result_t                result
);

    tcf_pkg::phase_t                   phase_reg, phase_next;
    logic [tcf_pkg::TAG_LEN_W-1:0]     count_reg, count_next;
    logic                              miss_reg, miss_next;
    logic                              emitted_reg, emitted_next;
    logic                              byte_hit;

    // Tag character at the current match position equals the input word
    always_comb
    begin
        byte_hit = 1'b0;
        for (int k = 0; k < MAX_TAG_BYTES; k++)
        begin
            if (count_reg == tcf_pkg::TAG_LEN_W'(k) &&
                tag[k*8 +: 8] == in_byte)
                byte_hit = 1'b1;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        miss_next    = miss_reg;
        emitted_next = emitted_reg;
        result.emit  = 1'b0;
        result.data  = in_byte;

        if (step)
        begin
            if (end_of_stream)
            begin
                result.emit  = (phase_reg == tcf_pkg::PH_PASS) && emitted_reg;
                result.data  = tcf_pkg::CH_NL;
                phase_next   = tcf_pkg::PH_COL1;
                count_next   = '0;
                miss_next    = 1'b0;
                emitted_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    tcf_pkg::PH_COL1:
                    begin
                        if (in_byte == tcf_pkg::CH_TAB)
                        begin
                            if (!miss_reg && count_reg == tag_len)
                            begin
                                phase_next   = tcf_pkg::PH_PASS;
                                emitted_next = 1'b0;
                            end
                            else
                                phase_next = tcf_pkg::PH_SKIP;
                        end
                        else if (in_byte == tcf_pkg::CH_NL)
                        begin
                            count_next   = '0;
                            miss_next    = 1'b0;
                            emitted_next = 1'b0;
                        end
                        else if (!miss_reg)
                        begin
                            if (count_reg < tag_len && byte_hit)
                                count_next = count_reg + 1'b1;
                            else
                                miss_next = 1'b1;
                        end
                    end
                    tcf_pkg::PH_PASS:
                    begin
                        if (in_byte == tcf_pkg::CH_NL)
                        begin
                            result.emit  = emitted_reg;
                            phase_next   = tcf_pkg::PH_COL1;
                            count_next   = '0;
                            miss_next    = 1'b0;
                            emitted_next = 1'b0;
                        end
                        else
                        begin
                            result.emit  = 1'b1;
                            emitted_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        // skipping rest of line
                        if (in_byte == tcf_pkg::CH_NL)
                        begin
                            phase_next   = tcf_pkg::PH_COL1;
                            count_next   = '0;
                            miss_next    = 1'b0;
                            emitted_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tcf_pkg::PH_COL1;
            count_reg   <= '0;
            miss_reg    <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            miss_reg    <= miss_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ----- design/tcf_out_reg.sv -----
// ----------------------------------------------------------------------------
// tcf_out_reg
// Output register holding one result word until taken downstream.
// ----------------------------------------------------------------------------
module tcf_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  tcf_pkg::result_t            result,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcf_pkg::BYTE_W-1:0]  out_byte
);

    logic                        valid_reg, valid_next;
    logic [tcf_pkg::BYTE_W-1:0]  data_reg, data_next;

    // Slot is free when empty or drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        if (load && result.emit)
        begin
            valid_next = 1'b1;
            data_next  = result.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg;

endmodule

// ----- sim/tb_tsv_tag_column_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_tsv_tag_column_filter_core
// Self-checking bench for the tag column filter. Streams tab-separated
// lines built around the configured tag (exact hits, near misses, short and
// overlong first columns, noise) under several tag settings and idle
// patterns, and checks every output word against a line-state predictor.
// ----------------------------------------------------------------------------

// Predicts the filtered byte stream and checks the block's output words
class tag_filter_board;

    logic [63:0]     tag_bytes;
    logic [3:0]      tag_length;
    tcf_pkg::phase_t phase;
    logic [3:0]      matched;
    bit              col_failed;
    bit              emitted;
    logic [7:0]      expected_bytes[$];
    int unsigned     errors;

    function new();
        tag_bytes  = tcf_pkg::TAG_BYTES_RST;
        tag_length = tcf_pkg::TAG_LENGTH_RST;
        errors     = 0;
        start_line();
    endfunction

    function void start_line();
        phase      = tcf_pkg::PH_COL1;
        matched    = 4'd0;
        col_failed = 1'b0;
        emitted    = 1'b0;
    endfunction

    // Lengths above the tag store are clamped
    function int tag_len_eff();
        return (tag_length > 4'd8) ? 8 : int'(tag_length);
    endfunction

    function void write_reg(logic [tcf_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] data);
        if (idx == tcf_pkg::REG_TAG_BYTES)
            tag_bytes = data;
        else if (idx == tcf_pkg::REG_TAG_LENGTH)
            tag_length = data[3:0];
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    // One accepted input word
    function void note_word(logic [7:0] b, logic eos);
        int len;
        len = tag_len_eff();
        if (eos)
        begin
            if (phase == tcf_pkg::PH_PASS && emitted)
                expected_bytes.push_back(tcf_pkg::CH_NL);
            start_line();
        end
        else if (phase == tcf_pkg::PH_COL1)
        begin
            if (b == tcf_pkg::CH_TAB)
            begin
                if (!col_failed && int'(matched) == len)
                begin
                    phase   = tcf_pkg::PH_PASS;
                    emitted = 1'b0;
                end
                else
                begin
                    phase = tcf_pkg::PH_SKIP;
                end
            end
            else if (b == tcf_pkg::CH_NL)
            begin
                start_line();
            end
            else if (!col_failed)
            begin
                if (int'(matched) < len && tag_bytes[8*matched +: 8] == b)
                    matched = matched + 4'd1;
                else
                    col_failed = 1'b1;
            end
        end
        else if (phase == tcf_pkg::PH_PASS)
        begin
            if (b == tcf_pkg::CH_NL)
            begin
                if (emitted)
                    expected_bytes.push_back(tcf_pkg::CH_NL);
                start_line();
            end
            else
            begin
                emitted = 1'b1;
                expected_bytes.push_back(b);
            end
        end
        else if (b == tcf_pkg::CH_NL)
        begin
            // skipping: only a newline matters
            start_line();
        end
    endfunction

    // One accepted output word
    function void check_byte(logic [7:0] actual);
        logic [7:0] exp_b;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected out_byte %h", actual);
        end
        else
        begin
            exp_b = expected_bytes.pop_front();
            if (exp_b !== actual)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: out_byte expected %h actual %h", exp_b, actual);
            end
        end
    endfunction

endclass

module tb_tsv_tag_column_filter_core;

    import tcf_pkg::*;

    localparam int MAX_TAG_BYTES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int WORDS_PER_SET = 100;
    localparam int NUM_SETTINGS  = 9;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      in_byte;
    logic                   end_of_stream;
    logic                   out_valid;
    logic                   out_ready;
    logic [BYTE_W-1:0]      out_byte;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tag_filter_board board;
    int              snd_idle_pct;
    int              rcv_stall_pct;
    int              words_sent;
    int              cycle_count;

    tsv_tag_column_filter_core #(
        .MAX_TAG_BYTES(MAX_TAG_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver side: random stall per cycle
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
    end

    // Watch all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                board.note_word(in_byte, end_of_stream);
            if (out_valid && out_ready)
                board.check_byte(out_byte);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive one input word; returns at the edge that takes it
    task automatic send_word(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // First n characters of the current tag
    task automatic send_tag(input int n);
        for (int k = 0; k < n; k++)
            send_word(board.tag_bytes[8*k +: 8], 1'b0);
    endtask

    // Column-one filler: anything but tab and newline
    function automatic logic [7:0] col_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_TAB || b == CH_NL)
            b = 8'h5F;
        return b;
    endfunction

    // Passed-part byte: no newline, tabs now and then
    function automatic logic [7:0] rest_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_NL || $urandom_range(7) == 0)
            b = CH_TAB;
        return b;
    endfunction

    // One random line, mostly shaped around the tag
    task automatic send_random_line();
        int         kind;
        int         n;
        int         pick;
        logic [7:0] b;
        n    = board.tag_len_eff();
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3, 4: send_tag(n);
            5:
            begin
                // short first column
                if (n > 0) send_tag($urandom_range(n - 1));
                else       send_word(col_byte(), 1'b0);
            end
            6:
            begin
                // overlong first column
                send_tag(n);
                send_word(col_byte(), 1'b0);
            end
            7:
            begin
                // one tag character altered
                if (n == 0)
                begin
                    send_word(col_byte(), 1'b0);
                end
                else
                begin
                    pick = $urandom_range(n - 1);
                    for (int k = 0; k < n; k++)
                    begin
                        b = board.tag_bytes[8*k +: 8];
                        if (k == pick)
                            b = b ^ 8'($urandom_range(1, 255));
                        send_word(b, 1'b0);
                    end
                end
            end
            8:
            begin
                // line ends before any tab
                send_tag($urandom_range(n));
                repeat ($urandom_range(3)) send_word(col_byte(), 1'b0);
            end
            default:
            begin
                // raw noise
                repeat ($urandom_range(1, 12)) send_word(8'($urandom_range(255)), 1'b0);
            end
        endcase
        if (kind <= 7)
        begin
            send_word(CH_TAB, 1'b0);
            repeat ($urandom_range(10)) send_word(rest_byte(), 1'b0);
        end
        if (kind <= 8)
        begin
            if ($urandom_range(5) == 0) send_word(8'($urandom_range(255)), 1'b1);
            else                        send_word(CH_NL, 1'b0);
        end
    endtask

    // Quiet the input and let all expected words come out; the first edge
    // lets the last taken word reach the board
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] make_tag();
        logic [63:0] t;
        logic [7:0]  c;
        for (int k = 0; k < 8; k++)
        begin
            if ($urandom_range(3) == 0) c = col_byte();
            else                        c = 8'($urandom_range(32, 126));
            t[8*k +: 8] = c;
        end
        return t;
    endfunction

    // Tag settings, extremes first
    task automatic apply_setting(input int s);
        logic [63:0] len_word;
        len_word = {$urandom, $urandom};
        case (s)
            0:
            begin
                // empty tag
                cfg_write(REG_TAG_BYTES, make_tag());
                cfg_write(REG_TAG_LENGTH, 64'd0);
            end
            1:
            begin
                cfg_write(REG_TAG_BYTES, {64{1'b1}});
                cfg_write(REG_TAG_LENGTH, 64'd8);
            end
            2:
            begin
                cfg_write(REG_TAG_BYTES, 64'd0);
                cfg_write(REG_TAG_LENGTH, 64'd3);
            end
            3:
            begin
                // oversized length, junk in the upper bits
                cfg_write(REG_TAG_BYTES, make_tag());
                cfg_write(REG_TAG_LENGTH, {len_word[63:4], 4'd15});
            end
            4:
            begin
                cfg_write(REG_TAG_BYTES, make_tag());
                cfg_write(REG_TAG_LENGTH, 64'd9);
            end
            5:
            begin
                cfg_write(REG_TAG_BYTES, TAG_BYTES_RST);
                cfg_write(REG_TAG_LENGTH, 64'(TAG_LENGTH_RST));
            end
            default:
            begin
                cfg_write(REG_TAG_BYTES, make_tag());
                cfg_write(REG_TAG_LENGTH, 64'($urandom_range(15)));
            end
        endcase
    endtask

    // Stimulus
    initial
    begin
        board         = new();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        words_sent    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        end_of_stream <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_TAG_BYTES;
        cfg_data      <= 64'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines with the reset tag
        send_str("D\tab\n");
        send_str("D\t\n");          // matched, nothing passed
        send_str("D\n");            // newline in column one
        send_str("D\tz");
        send_word(8'hA5, 1'b1);     // end of stream closes the line
        send_str("D\t");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_NL, 1'b0);
        send_str("DD\tk\n");        // first column too long

        // Random lines, one tag setting and idle pattern per phase
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain();
            apply_setting(s);
            case (s % 4)
                0:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    snd_idle_pct  = 72;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 72;
                end
                default:
                begin
                    snd_idle_pct  = 21;
                    rcv_stall_pct = 21;
                end
            endcase
            words_sent = 0;
            while (words_sent < WORDS_PER_SET)
                send_random_line();
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
